>>> rtl/core/tilemap_quad_builder_and_collider_defines.svh
// ---------------------------------------------------------------------------
// tilemap quad builder and collider assertion macros
// concurrent checks on aclk, disabled while aresetn is low
// ---------------------------------------------------------------------------
`ifndef TILEMAP_QUAD_BUILDER_AND_COLLIDER_DEFINES_SVH
`define TILEMAP_QUAD_BUILDER_AND_COLLIDER_DEFINES_SVH

`ifndef SYNTHESIS
`define TQBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define TQBC_ASSERT_NEXT(label, cond, nxt, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) cond |=> nxt) else $error(msg);
`else
`define TQBC_ASSERT(label, prop, msg)
`define TQBC_ASSERT_NEXT(label, cond, nxt, msg)
`endif

`endif

>>> rtl/core/tqbc_pkg.sv
// ---------------------------------------------------------------------------
// tqbc_pkg
// shared constants, types and helpers of the tilemap quad builder
// ---------------------------------------------------------------------------
`default_nettype none

package tqbc_pkg;

    localparam int MAX_MAP_WIDTH  = 64;
    localparam int MAX_MAP_HEIGHT = 64;
    localparam int STORE_DEPTH    = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
    localparam int ADDR_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_W          = (MAX_MAP_WIDTH > 1) ? $clog2(MAX_MAP_WIDTH) : 1;
    localparam int ROW_W          = (MAX_MAP_HEIGHT > 1) ? $clog2(MAX_MAP_HEIGHT) : 1;
    localparam int WDIM_W         = $clog2(MAX_MAP_WIDTH + 1);
    localparam int HDIM_W         = $clog2(MAX_MAP_HEIGHT + 1);
    localparam int MUL_A_W        = (WDIM_W > HDIM_W) ? WDIM_W : HDIM_W;

    localparam int TILE_W   = 10;
    localparam int MDIM_W   = 7;
    localparam int ATL_W    = 6;
    localparam int TS_W     = 16;
    localparam int SPAN_W   = 24;
    localparam int HALF_W   = 23;
    localparam int POS_W    = 32;
    localparam int UV_W     = 17;
    localparam int PEN_W    = 23;
    localparam int EDGE_K_W = 11;
    localparam int PROD_W   = MUL_A_W + SPAN_W;

    localparam int DVD_W = 32;
    localparam int DSR_W = 24;
    localparam int CNT_W = $clog2(DVD_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 80;
    localparam int M_FIELD_W = 2 * POS_W + 2 * UV_W + 1 + 2 * PEN_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd4;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    localparam logic [UV_W-1:0] UV_ONE = 17'h10000;

    localparam int NUM_VERTS = 6;
    localparam int VTX_W     = 3;
    // per vertex: set where the far x / lower y edge is used
    localparam logic [NUM_VERTS-1:0] X1_SEL = 6'b110100;
    localparam logic [NUM_VERTS-1:0] Y1_SEL = 6'b010110;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DSR_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [ADDR_W-1:0] tile_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(row) * ADDR_W'(MAX_MAP_WIDTH);
        return base + ADDR_W'(col);
    endfunction

    function automatic logic [WDIM_W-1:0] clamp_w(input logic [MDIM_W-1:0] v);
        logic [WDIM_W-1:0] r;
        if (v == '0) begin
            r = WDIM_W'(1);
        end else if (int'(v) > MAX_MAP_WIDTH) begin
            r = WDIM_W'(MAX_MAP_WIDTH);
        end else begin
            r = WDIM_W'(v);
        end
        return r;
    endfunction

    function automatic logic [HDIM_W-1:0] clamp_h(input logic [MDIM_W-1:0] v);
        logic [HDIM_W-1:0] r;
        if (v == '0) begin
            r = HDIM_W'(1);
        end else if (int'(v) > MAX_MAP_HEIGHT) begin
            r = HDIM_W'(MAX_MAP_HEIGHT);
        end else begin
            r = HDIM_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tqbc_div.sv
// ---------------------------------------------------------------------------
// tqbc_div
// shared restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module tqbc_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tqbc_pkg::div_req_t req,
    output tqbc_pkg::div_rsp_t      rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [tqbc_pkg::CNT_W-1:0]   cnt_reg;
    logic [tqbc_pkg::DVD_W-1:0]   quot_reg;
    logic [tqbc_pkg::DSR_W-1:0]   rem_reg;
    logic [tqbc_pkg::DSR_W-1:0]   dsr_reg;
    logic [tqbc_pkg::DSR_W:0]     shifted;
    logic [tqbc_pkg::DSR_W:0]     diff;
    logic                         ge;

    assign shifted = {rem_reg, quot_reg[tqbc_pkg::DVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign ge      = !diff[tqbc_pkg::DSR_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start
                     && (cnt_reg == tqbc_pkg::CNT_W'(tqbc_pkg::DVD_W - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quot_reg <= req.dividend;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
            end else if (busy_reg) begin
                quot_reg <= {quot_reg[tqbc_pkg::DVD_W-2:0], ge};
                rem_reg  <= ge ? diff[tqbc_pkg::DSR_W-1:0] : shifted[tqbc_pkg::DSR_W-1:0];
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == tqbc_pkg::CNT_W'(tqbc_pkg::DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/tqbc_store.sv
// ---------------------------------------------------------------------------
// tqbc_store
// level map memory, swept to empty after reset
// ---------------------------------------------------------------------------
`default_nettype none

module tqbc_store (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [tqbc_pkg::ADDR_W-1:0]   wr_addr,
    input  wire logic [tqbc_pkg::TILE_W-1:0]   wr_data,
    input  wire logic                          rd_en,
    input  wire logic [tqbc_pkg::ADDR_W-1:0]   rd_addr,
    output logic      [tqbc_pkg::TILE_W-1:0]   rd_data,
    output logic                               clearing
);

    logic [tqbc_pkg::TILE_W-1:0] mem [tqbc_pkg::STORE_DEPTH];
    logic [tqbc_pkg::ADDR_W-1:0] clr_cnt_reg;
    logic                        clearing_reg;
    logic [tqbc_pkg::TILE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == tqbc_pkg::ADDR_W'(tqbc_pkg::STORE_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_cnt_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

`default_nettype wire

>>> rtl/core/tilemap_quad_builder_and_collider.sv
// ---------------------------------------------------------------------------
// tilemap_quad_builder_and_collider
// tile loader with quad vertex output and point-versus-tile collision query
// ---------------------------------------------------------------------------
// a nonempty load runs five divides through the shared divider, two
//   multiplies and six vertex items; an empty load only writes the map
// a query runs up to two divides and one memory read
// items are handled one at a time; no new item is accepted until the last is done
// reset: synchronous active low; the level map is swept to empty after
//   reset, no item is accepted until the sweep ends
`default_nettype none
`include "tilemap_quad_builder_and_collider_defines.svh"

module tilemap_quad_builder_and_collider (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tile_value, pos_x, pos_y
    input  wire logic [tqbc_pkg::S_TDATA_W-1:0]    s_tdata,
    // mode
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // vert_x, vert_y, tex_u, tex_v, solid, pen_x, pen_y
    output logic      [tqbc_pkg::M_TDATA_W-1:0]    m_tdata,
    // kind
    output logic                                   m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tqbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tqbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LD_DIV,
        ST_LD_EDGE,
        ST_LD_MULX,
        ST_LD_MULY,
        ST_LD_EMIT,
        ST_Q_MULX,
        ST_Q_MULY,
        ST_Q_CHK,
        ST_Q_DIVX,
        ST_Q_DIVY,
        ST_Q_RD,
        ST_Q_RDW,
        ST_Q_EMIT
    } state_t;

    // configuration
    logic [tqbc_pkg::MDIM_W-1:0] map_width_reg;
    logic [tqbc_pkg::MDIM_W-1:0] map_height_reg;
    logic [tqbc_pkg::ATL_W-1:0]  atlas_columns_reg;
    logic [tqbc_pkg::ATL_W-1:0]  atlas_rows_reg;
    logic [tqbc_pkg::TS_W-1:0]   tile_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg     <= tqbc_pkg::MDIM_W'(16);
            map_height_reg    <= tqbc_pkg::MDIM_W'(16);
            atlas_columns_reg <= tqbc_pkg::ATL_W'(4);
            atlas_rows_reg    <= tqbc_pkg::ATL_W'(4);
            tile_size_reg     <= tqbc_pkg::TS_W'(256);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tqbc_pkg::REG_MAP_WIDTH: begin
                    map_width_reg <= cfg_wdata[tqbc_pkg::MDIM_W-1:0];
                end
                tqbc_pkg::REG_MAP_HEIGHT: begin
                    map_height_reg <= cfg_wdata[tqbc_pkg::MDIM_W-1:0];
                end
                tqbc_pkg::REG_ATLAS_COLUMNS: begin
                    atlas_columns_reg <= cfg_wdata[tqbc_pkg::ATL_W-1:0];
                end
                tqbc_pkg::REG_ATLAS_ROWS: begin
                    atlas_rows_reg <= cfg_wdata[tqbc_pkg::ATL_W-1:0];
                end
                tqbc_pkg::REG_TILE_SIZE: begin
                    tile_size_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // effective settings
    logic [tqbc_pkg::WDIM_W-1:0] w_eff;
    logic [tqbc_pkg::HDIM_W-1:0] h_eff;
    logic [tqbc_pkg::ATL_W-1:0]  a_eff;
    logic [tqbc_pkg::ATL_W-1:0]  b_eff;
    logic [tqbc_pkg::TS_W-1:0]   ts_eff;
    logic [tqbc_pkg::SPAN_W-1:0] span;
    logic [tqbc_pkg::HALF_W-1:0] half;

    assign w_eff  = tqbc_pkg::clamp_w(map_width_reg);
    assign h_eff  = tqbc_pkg::clamp_h(map_height_reg);
    assign a_eff  = (atlas_columns_reg == '0) ? tqbc_pkg::ATL_W'(1) : atlas_columns_reg;
    assign b_eff  = (atlas_rows_reg == '0) ? tqbc_pkg::ATL_W'(1) : atlas_rows_reg;
    assign ts_eff = (tile_size_reg == '0) ? tqbc_pkg::TS_W'(1) : tile_size_reg;
    assign span   = {ts_eff, 8'b0};
    assign half   = {ts_eff, 7'b0};

    // input fields
    logic [tqbc_pkg::TILE_W-1:0] in_tile;
    logic [tqbc_pkg::POS_W-1:0]  in_x;
    logic [tqbc_pkg::POS_W-1:0]  in_y;
    logic                        in_mode;

    assign in_tile = s_tdata[9:0];
    assign in_x    = s_tdata[41:10];
    assign in_y    = s_tdata[73:42];
    assign in_mode = s_tuser;

    // sequencer registers
    state_t                        state_reg;
    logic [tqbc_pkg::COL_W-1:0]    lcol_reg;
    logic [tqbc_pkg::ROW_W-1:0]    lrow_reg;
    logic [tqbc_pkg::COL_W-1:0]    col_reg;
    logic [tqbc_pkg::ROW_W-1:0]    row_reg;
    logic [tqbc_pkg::TILE_W-1:0]   tq_reg;
    logic [tqbc_pkg::ATL_W-1:0]    tr_reg;
    logic [1:0]                    edge_idx_reg;
    logic [tqbc_pkg::UV_W-1:0]     u0_reg;
    logic [tqbc_pkg::UV_W-1:0]     u1_reg;
    logic [tqbc_pkg::UV_W-1:0]     v0_reg;
    logic [tqbc_pkg::UV_W-1:0]     v1_reg;
    logic [tqbc_pkg::PROD_W-1:0]   prod_x_reg;
    logic [tqbc_pkg::PROD_W-1:0]   prod_y_reg;
    logic [tqbc_pkg::POS_W-1:0]    px_reg;
    logic [tqbc_pkg::POS_W-1:0]    py_reg;
    logic [tqbc_pkg::DVD_W-1:0]    yh_reg;
    logic [tqbc_pkg::DSR_W-1:0]    rem_x_reg;
    logic [tqbc_pkg::DSR_W-1:0]    rem_y_reg;
    logic [tqbc_pkg::VTX_W-1:0]    vtx_reg;
    logic                          solid_reg;
    logic [tqbc_pkg::PEN_W-1:0]    pen_x_reg;
    logic [tqbc_pkg::PEN_W-1:0]    pen_y_reg;
    tqbc_pkg::div_req_t            div_req_reg;
    logic                          m_tvalid_reg;
    logic [tqbc_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tuser_reg;
    logic                          m_tlast_reg;

    tqbc_pkg::div_rsp_t            div_rsp;
    logic [tqbc_pkg::TILE_W-1:0]   store_rd_data;
    logic                          store_clearing;

    logic                          accept;
    logic                          slot_free;
    logic                          emit_fire;
    logic                          div_start;

    assign accept    = s_tvalid && s_tready;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign emit_fire = slot_free && (state_reg inside {ST_LD_EMIT, ST_Q_EMIT});

    // load position, wrapped before use
    logic [tqbc_pkg::COL_W-1:0] ld_col;
    logic [tqbc_pkg::ROW_W-1:0] ld_row;
    logic [tqbc_pkg::COL_W-1:0] lcol_next;
    logic [tqbc_pkg::ROW_W-1:0] lrow_next;

    always_comb begin
        ld_col    = (int'(lcol_reg) >= int'(w_eff)) ? '0 : lcol_reg;
        ld_row    = (int'(lrow_reg) >= int'(h_eff)) ? '0 : lrow_reg;
        lcol_next = ld_col + 1'b1;
        lrow_next = ld_row;
        if (int'(ld_col) + 1 >= int'(w_eff)) begin
            lcol_next = '0;
            lrow_next = (int'(ld_row) + 1 >= int'(h_eff)) ? '0 : ld_row + 1'b1;
        end
    end

    // next atlas edge divide
    logic [tqbc_pkg::EDGE_K_W-1:0] edge_k;
    logic [tqbc_pkg::ATL_W-1:0]    edge_n;
    logic [tqbc_pkg::UV_W-1:0]     edge_sat;

    always_comb begin
        case (edge_idx_reg)
            2'd0: begin
                edge_k = tqbc_pkg::EDGE_K_W'(tr_reg) + 1'b1;
                edge_n = a_eff;
            end
            2'd1: begin
                edge_k = tqbc_pkg::EDGE_K_W'(tq_reg);
                edge_n = b_eff;
            end
            2'd2: begin
                edge_k = tqbc_pkg::EDGE_K_W'(tq_reg) + 1'b1;
                edge_n = b_eff;
            end
            default: begin
                edge_k = '0;
                edge_n = b_eff;
            end
        endcase
        edge_sat = (div_rsp.quot > tqbc_pkg::DVD_W'(tqbc_pkg::UV_ONE)) ?
                   tqbc_pkg::UV_ONE : div_rsp.quot[tqbc_pkg::UV_W-1:0];
    end

    // shared multiplier operand
    logic [tqbc_pkg::MUL_A_W-1:0] mul_a;
    logic [tqbc_pkg::PROD_W-1:0]  mul_p;

    always_comb begin
        case (state_reg)
            ST_LD_MULX: mul_a = tqbc_pkg::MUL_A_W'(col_reg);
            ST_LD_MULY: mul_a = tqbc_pkg::MUL_A_W'(row_reg);
            ST_Q_MULX:  mul_a = tqbc_pkg::MUL_A_W'(w_eff);
            default:    mul_a = tqbc_pkg::MUL_A_W'(h_eff);
        endcase
        mul_p = tqbc_pkg::PROD_W'(mul_a) * tqbc_pkg::PROD_W'(span);
    end

    // query bounds
    logic [tqbc_pkg::POS_W+1:0] xh;
    logic [tqbc_pkg::POS_W+1:0] yh;
    logic                       q_oob;

    assign xh    = {{2{px_reg[tqbc_pkg::POS_W-1]}}, px_reg}
                 + (tqbc_pkg::POS_W+2)'(half);
    assign yh    = (tqbc_pkg::POS_W+2)'(half)
                 - {{2{py_reg[tqbc_pkg::POS_W-1]}}, py_reg};
    assign q_oob = xh[tqbc_pkg::POS_W+1] || yh[tqbc_pkg::POS_W+1]
                || (xh > (tqbc_pkg::POS_W+2)'(prod_x_reg))
                || (yh > (tqbc_pkg::POS_W+2)'(prod_y_reg));

    // divider start
    always_comb begin
        case (state_reg)
            ST_IDLE: begin
                div_start = accept && (in_mode == tqbc_pkg::MODE_LOAD) && (in_tile != '0);
            end
            ST_LD_DIV: begin
                div_start = div_rsp.done;
            end
            ST_LD_EDGE: begin
                div_start = div_rsp.done && (edge_idx_reg != 2'd3);
            end
            ST_Q_CHK: begin
                div_start = !q_oob;
            end
            ST_Q_DIVX: begin
                div_start = div_rsp.done && (div_rsp.quot < tqbc_pkg::DVD_W'(w_eff));
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // penetration from the remainders within the tile
    logic signed [tqbc_pkg::DSR_W:0] dx;
    logic signed [tqbc_pkg::DSR_W:0] dy;
    logic [tqbc_pkg::DSR_W:0]        adx;
    logic [tqbc_pkg::DSR_W:0]        ady;
    logic [tqbc_pkg::PEN_W-1:0]      pen_x;
    logic [tqbc_pkg::PEN_W-1:0]      pen_y;

    always_comb begin
        dx    = $signed({1'b0, rem_x_reg}) - $signed({2'b0, half});
        dy    = $signed({1'b0, rem_y_reg}) - $signed({2'b0, half});
        adx   = dx[tqbc_pkg::DSR_W] ? -dx : dx;
        ady   = dy[tqbc_pkg::DSR_W] ? -dy : dy;
        pen_x = half - adx[tqbc_pkg::PEN_W-1:0];
        pen_y = half - ady[tqbc_pkg::PEN_W-1:0];
    end

    // vertex fields
    logic [tqbc_pkg::POS_W-1:0] x0;
    logic [tqbc_pkg::POS_W-1:0] x1;
    logic [tqbc_pkg::POS_W-1:0] y0;
    logic [tqbc_pkg::POS_W-1:0] y1;
    logic [tqbc_pkg::POS_W-1:0] vx;
    logic [tqbc_pkg::POS_W-1:0] vy;
    logic [tqbc_pkg::UV_W-1:0]  tu;
    logic [tqbc_pkg::UV_W-1:0]  tv;

    always_comb begin
        x0 = tqbc_pkg::POS_W'(prod_x_reg) - tqbc_pkg::POS_W'(half);
        x1 = x0 + tqbc_pkg::POS_W'(span);
        y0 = tqbc_pkg::POS_W'(half) - tqbc_pkg::POS_W'(prod_y_reg);
        y1 = y0 - tqbc_pkg::POS_W'(span);
        vx = tqbc_pkg::X1_SEL[vtx_reg] ? x1 : x0;
        vy = tqbc_pkg::Y1_SEL[vtx_reg] ? y1 : y0;
        tu = tqbc_pkg::X1_SEL[vtx_reg] ? u1_reg : u0_reg;
        tv = tqbc_pkg::Y1_SEL[vtx_reg] ? v1_reg : v0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_CLEAR;
            lcol_reg          <= '0;
            lrow_reg          <= '0;
            vtx_reg           <= '0;
            edge_idx_reg      <= '0;
            div_req_reg.start <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            div_req_reg.start <= div_start;
            m_tvalid_reg      <= emit_fire || (m_tvalid_reg && !m_tready);
            case (state_reg)
                ST_CLEAR: begin
                    if (!store_clearing) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        if (in_mode == tqbc_pkg::MODE_LOAD) begin
                            lcol_reg <= lcol_next;
                            lrow_reg <= lrow_next;
                            col_reg  <= ld_col;
                            row_reg  <= ld_row;
                            if (in_tile != '0) begin
                                div_req_reg.dividend <= tqbc_pkg::DVD_W'(in_tile);
                                div_req_reg.divisor  <= tqbc_pkg::DSR_W'(a_eff);
                                state_reg            <= ST_LD_DIV;
                            end
                        end else begin
                            px_reg    <= in_x;
                            py_reg    <= in_y;
                            solid_reg <= 1'b0;
                            pen_x_reg <= '0;
                            pen_y_reg <= '0;
                            state_reg <= ST_Q_MULX;
                        end
                    end
                end
                ST_LD_DIV: begin
                    if (div_rsp.done) begin
                        tq_reg               <= div_rsp.quot[tqbc_pkg::TILE_W-1:0];
                        tr_reg               <= div_rsp.rem[tqbc_pkg::ATL_W-1:0];
                        edge_idx_reg         <= '0;
                        div_req_reg.dividend <= tqbc_pkg::DVD_W'(
                            {div_rsp.rem[tqbc_pkg::ATL_W-1:0], 16'b0});
                        div_req_reg.divisor  <= tqbc_pkg::DSR_W'(a_eff);
                        state_reg            <= ST_LD_EDGE;
                    end
                end
                ST_LD_EDGE: begin
                    if (div_rsp.done) begin
                        case (edge_idx_reg)
                            2'd0:    u0_reg <= edge_sat;
                            2'd1:    u1_reg <= edge_sat;
                            2'd2:    v0_reg <= edge_sat;
                            default: v1_reg <= edge_sat;
                        endcase
                        edge_idx_reg <= edge_idx_reg + 1'b1;
                        if (edge_idx_reg == 2'd3) begin
                            state_reg <= ST_LD_MULX;
                        end else begin
                            div_req_reg.dividend <= tqbc_pkg::DVD_W'({edge_k, 16'b0});
                            div_req_reg.divisor  <= tqbc_pkg::DSR_W'(edge_n);
                        end
                    end
                end
                ST_LD_MULX: begin
                    prod_x_reg <= mul_p;
                    state_reg  <= ST_LD_MULY;
                end
                ST_LD_MULY: begin
                    prod_y_reg <= mul_p;
                    vtx_reg    <= '0;
                    state_reg  <= ST_LD_EMIT;
                end
                ST_LD_EMIT: begin
                    if (slot_free) begin
                        m_tuser_reg  <= tqbc_pkg::KIND_VERTEX;
                        m_tlast_reg  <= (vtx_reg == tqbc_pkg::VTX_W'(tqbc_pkg::NUM_VERTS - 1));
                        m_tdata_reg  <= {{tqbc_pkg::M_PAD_W{1'b0}},
                                         {tqbc_pkg::PEN_W{1'b0}}, {tqbc_pkg::PEN_W{1'b0}},
                                         1'b0, tv, tu, vy, vx};
                        if (vtx_reg == tqbc_pkg::VTX_W'(tqbc_pkg::NUM_VERTS - 1)) begin
                            vtx_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            vtx_reg <= vtx_reg + 1'b1;
                        end
                    end
                end
                ST_Q_MULX: begin
                    prod_x_reg <= mul_p;
                    state_reg  <= ST_Q_MULY;
                end
                ST_Q_MULY: begin
                    prod_y_reg <= mul_p;
                    state_reg  <= ST_Q_CHK;
                end
                ST_Q_CHK: begin
                    if (q_oob) begin
                        state_reg <= ST_Q_EMIT;
                    end else begin
                        yh_reg               <= yh[tqbc_pkg::DVD_W-1:0];
                        div_req_reg.dividend <= xh[tqbc_pkg::DVD_W-1:0];
                        div_req_reg.divisor  <= span;
                        state_reg            <= ST_Q_DIVX;
                    end
                end
                ST_Q_DIVX: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quot >= tqbc_pkg::DVD_W'(w_eff)) begin
                            state_reg <= ST_Q_EMIT;
                        end else begin
                            col_reg              <= div_rsp.quot[tqbc_pkg::COL_W-1:0];
                            rem_x_reg            <= div_rsp.rem;
                            div_req_reg.dividend <= yh_reg;
                            div_req_reg.divisor  <= span;
                            state_reg            <= ST_Q_DIVY;
                        end
                    end
                end
                ST_Q_DIVY: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quot >= tqbc_pkg::DVD_W'(h_eff)) begin
                            state_reg <= ST_Q_EMIT;
                        end else begin
                            row_reg   <= div_rsp.quot[tqbc_pkg::ROW_W-1:0];
                            rem_y_reg <= div_rsp.rem;
                            state_reg <= ST_Q_RD;
                        end
                    end
                end
                ST_Q_RD: begin
                    state_reg <= ST_Q_RDW;
                end
                ST_Q_RDW: begin
                    if (store_rd_data != '0) begin
                        solid_reg <= 1'b1;
                        pen_x_reg <= pen_x;
                        pen_y_reg <= pen_y;
                    end
                    state_reg <= ST_Q_EMIT;
                end
                ST_Q_EMIT: begin
                    if (slot_free) begin
                        m_tuser_reg  <= tqbc_pkg::KIND_ANSWER;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {{tqbc_pkg::M_PAD_W{1'b0}}, pen_y_reg, pen_x_reg,
                                         solid_reg, {tqbc_pkg::UV_W{1'b0}},
                                         {tqbc_pkg::UV_W{1'b0}}, {tqbc_pkg::POS_W{1'b0}},
                                         {tqbc_pkg::POS_W{1'b0}}};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tqbc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    tqbc_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (accept && (in_mode == tqbc_pkg::MODE_LOAD)),
        .wr_addr  (tqbc_pkg::tile_addr(ld_row, ld_col)),
        .wr_data  (in_tile),
        .rd_en    (state_reg == ST_Q_RD),
        .rd_addr  (tqbc_pkg::tile_addr(row_reg, col_reg)),
        .rd_data  (store_rd_data),
        .clearing (store_clearing)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `TQBC_ASSERT(a_ready_div_idle, s_tready |-> !div_rsp.busy, "ready while divider busy")
    `TQBC_ASSERT(a_answer_last, (m_tvalid && m_tuser) |-> m_tlast, "query answer without last")
    `TQBC_ASSERT(a_clear_blocks, store_clearing |-> !s_tready, "ready during map sweep")
    `TQBC_ASSERT_NEXT(a_done_pulse, div_rsp.done, !div_rsp.done, "divider done held")

endmodule

`default_nettype wire
